// ===== hw/rtl/nss_pkg.sv =====
`default_nettype none

package nss_pkg;

  // Field widths fixed by the interface.
  localparam int ACTION_W = 2;
  localparam int SIDX_W   = 4;
  localparam int SYM_W8   = 8;
  localparam int MASK_W   = 16;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_FEED  = 2'd2
  } nss_action_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_CLASS = 1'd1;

  localparam logic [SYM_W8-1:0] SYM_EPSILON     = 8'd64;
  localparam logic [SYM_W8-1:0] SYM_DIGIT_CLASS = 8'd126;
  localparam logic [SYM_W8-1:0] SYM_SPACE       = 8'd32;
  localparam logic [SYM_W8-1:0] DIGIT_LOW       = 8'd48;
  localparam logic [SYM_W8-1:0] DIGIT_HIGH      = 8'd57;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TGT,
    ST_CLS,
    ST_RESULT
  } nss_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nfa_subset_simulator.sv =====
`default_nettype none

// NFA subset simulator. The block keeps the set of active automaton states as
// a bitmask and steps it one input word at a time. A load word writes one
// transition entry (source state, symbol, target mask) into the transition
// RAM; symbol '@' is the epsilon row. A start word sets the active set to the
// epsilon closure of state 0, and a feed word replaces it by the epsilon
// closure of the union of targets of all active states for that character
// (a space is skipped, and digits can be folded onto '~'). Every input word
// returns exactly one output word with the active set, an accept flag against
// accept_mask and an empty-set flag. All work goes through one RAM read port
// and one OR-accumulate unit: a pass reads the row of every state for one
// symbol. A load, a skipped space or an unused action needs no pass; a start
// takes one pass per closure round; a feed takes one target pass plus the
// closure rounds. The closure stops as soon as a full pass adds no state.
// After reset the block sweeps the transition RAM to zero, one entry per
// cycle (NUM_STATES << clog2(SYMBOL_COUNT) entries, 4096 at the defaults),
// and holds in_stall high meanwhile; configuration writes are taken at any
// time. The output word sits in a register, so a new input word is accepted
// while the previous result still waits.
module nfa_subset_simulator
  import nss_pkg::*;
#(
  parameter int NUM_STATES   = 16,
  parameter int SYMBOL_COUNT = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Configuration write port.
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MASK_W-1:0]    cfg_wdata,
  // Input channel.
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [ACTION_W-1:0]  in_action,
  input  wire logic [SIDX_W-1:0]    in_state_index,
  input  wire logic [SYM_W8-1:0]    in_symbol,
  input  wire logic [MASK_W-1:0]    in_target_mask,
  // Result channel.
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [MASK_W-1:0]         out_active_set,
  output logic                      out_accepted,
  output logic                      out_dead
);

  // State index bits, pass counter bits (counts 0..NUM_STATES), symbol bits.
  localparam int SW    = $clog2(NUM_STATES);
  localparam int CW    = $clog2(NUM_STATES + 1);
  localparam int SYMW  = $clog2(SYMBOL_COUNT);
  localparam int DEPTH = NUM_STATES << SYMW;
  localparam int AW    = SW + SYMW;

  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(NUM_STATES);

  nss_state_t state_r, state_nxt;

  logic [MASK_W-1:0]     accept_mask_r;
  logic                  digit_on_r;

  logic [NUM_STATES-1:0] active_r, active_nxt;
  logic [NUM_STATES-1:0] work_r, work_nxt;
  logic [NUM_STATES-1:0] acc_r, acc_nxt;
  logic                  changed_r, changed_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [SYMW-1:0]       sym_r, sym_nxt;
  logic [AW-1:0]         clr_addr_r;

  logic [MASK_W-1:0]     out_active_set_r;
  logic                  out_accepted_r;
  logic                  out_dead_r;
  logic                  out_valid_r;

  // RAM port signals.
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [NUM_STATES-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [NUM_STATES-1:0] ram_rdata;

  // Decoded input word.
  logic                  in_fire;
  logic                  load_ok;
  logic [SYM_W8-1:0]     feed_sym;
  logic                  feed_sym_ok;
  logic                  feed_space;

  // Pass control.
  logic                  pass_end;
  logic                  data_here;
  logic [SW-1:0]         data_idx;
  logic                  out_free;
  logic                  out_load;
  logic                  cls_grew;

  nss_ram #(
    .WIDTH (NUM_STATES),
    .DEPTH (DEPTH)
  ) u_trans_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Input decode.
  // ---------------------------------------------------------------------------
  assign in_fire = in_valid && !in_stall;

  // Entries for states or symbols outside the table are dropped.
  assign load_ok = (7'(in_state_index) < 7'(NUM_STATES)) &&
                   ({1'b0, in_symbol} < 9'(SYMBOL_COUNT));

  always_comb begin
    feed_sym = in_symbol;
    if (digit_on_r && (in_symbol >= DIGIT_LOW) && (in_symbol <= DIGIT_HIGH)) begin
      feed_sym = SYM_DIGIT_CLASS;
    end
  end

  assign feed_sym_ok = {1'b0, feed_sym} < 9'(SYMBOL_COUNT);
  assign feed_space  = (in_symbol == SYM_SPACE);

  // A pass reads row cnt_r while the data of row cnt_r - 1 comes back.
  assign pass_end  = (cnt_r == CNT_END);
  assign data_here = (cnt_r != '0);
  assign data_idx  = SW'(cnt_r - CW'(1));

  assign out_free = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_action == ACT_START) begin
            state_nxt = ST_CLS;
          end else if (in_action == ACT_FEED && !feed_space && feed_sym_ok) begin
            state_nxt = ST_TGT;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_TGT: begin
        if (pass_end) begin
          state_nxt = ST_CLS;
        end
      end
      ST_CLS: begin
        if (pass_end && !cls_grew) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: control outputs.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = '0;
    ram_raddr = {cnt_r[SW-1:0], sym_r};
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        in_stall  = 1'b0;
        ram_we    = in_fire && (in_action == ACT_LOAD) && load_ok;
        ram_waddr = {SW'(in_state_index), SYMW'(in_symbol)};
        ram_wdata = NUM_STATES'(in_target_mask);
      end
      ST_TGT: begin
        ram_raddr = {cnt_r[SW-1:0], sym_r};
      end
      ST_CLS: begin
        ram_raddr = {cnt_r[SW-1:0], SYMW'(SYM_EPSILON)};
      end
      ST_RESULT: begin
        out_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath: the shared OR-accumulate unit.
  // ---------------------------------------------------------------------------
  always_comb begin
    active_nxt  = active_r;
    work_nxt    = work_r;
    acc_nxt     = acc_r;
    changed_nxt = changed_r;
    cnt_nxt     = cnt_r;
    sym_nxt     = sym_r;
    cls_grew    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt     = '0;
        changed_nxt = 1'b0;
        acc_nxt     = '0;
        sym_nxt     = SYMW'(feed_sym);
        if (in_fire && in_action == ACT_START) begin
          work_nxt = NUM_STATES'(1);
        end
        // A character beyond the table has no targets at all.
        if (in_fire && in_action == ACT_FEED && !feed_space && !feed_sym_ok) begin
          active_nxt = '0;
        end
      end
      ST_TGT: begin
        if (data_here && active_r[data_idx]) begin
          acc_nxt = acc_r | ram_rdata;
        end
        if (pass_end) begin
          work_nxt = acc_nxt;
          cnt_nxt  = '0;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_CLS: begin
        // A state added in a pass is expanded in it only if its row comes later.
        if (data_here && work_r[data_idx]) begin
          work_nxt = work_r | ram_rdata;
          if (work_nxt != work_r) begin
            changed_nxt = 1'b1;
          end
        end
        if (pass_end) begin
          cnt_nxt  = '0;
          cls_grew = changed_nxt;
          if (changed_nxt) begin
            changed_nxt = 1'b0;
          end else begin
            active_nxt = work_nxt;
          end
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_addr_r    <= '0;
      active_r      <= '0;
      cnt_r         <= '0;
      changed_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      accept_mask_r <= '0;
      digit_on_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      active_r  <= active_nxt;
      cnt_r     <= cnt_nxt;
      changed_r <= changed_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ACCEPT_MASK: accept_mask_r <= cfg_wdata;
          CFG_DIGIT_CLASS: digit_on_r    <= cfg_wdata[0];
          default:         digit_on_r    <= digit_on_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    acc_r  <= acc_nxt;
    sym_r  <= sym_nxt;
    if (out_load) begin
      out_active_set_r <= MASK_W'(active_r);
      out_accepted_r   <= |(MASK_W'(active_r) & accept_mask_r);
      out_dead_r       <= (active_r == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_active_set = out_active_set_r;
  assign out_accepted   = out_accepted_r;
  assign out_dead       = out_dead_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("output word appeared without a result step");

  a_ram_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_IDLE))
    else $error("transition RAM written during a pass");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_END)
    else $error("pass counter ran past the last state");

  a_accept_not_dead: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_accepted_r) |-> !out_dead_r)
    else $error("empty active set reported as accepting");

endmodule

`default_nettype wire

// ===== hw/rtl/nss_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module nss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the NFA subset simulator. Words go in on the input
// channel through one sender task, which also steps a behavioral copy of the
// automaton at the edge where the block accepts each word. The copy pushes
// the result word it expects onto a queue. A separate checker process pops
// that queue for every result word the block hands over and compares the
// fields one by one. The same process also drives out_stall on a shifting
// pattern, and on request holds it high for a long stretch.
module testbench;
  import nss_pkg::*;

  localparam int          CLK_PERIOD  = 10;
  localparam int          NUM_STATES  = 16;
  localparam int          SYM_COUNT   = 256;
  localparam int unsigned TOTAL_WORDS = 1750;
  localparam int unsigned HOLD_CYCLES = 1500;
  // This limit leaves room for the slowest legal run, the reset sweep and
  // every stall the bench can throw at it.
  localparam int unsigned RUN_LIMIT   = 3000000;
  localparam int unsigned SETTLE_CYCLES = 300;

  // Action code 3 has no meaning; the block must report the set unchanged.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [SYM_W8-1:0]   CH_A       = 8'h61;
  localparam logic [SYM_W8-1:0]   CH_Z       = 8'h7a;
  localparam logic [SYM_W8-1:0]   CH_NUL     = 8'h00;
  localparam logic [SYM_W8-1:0]   CH_TOP     = 8'hff;

  typedef struct packed {
    logic [MASK_W-1:0] active;
    logic              accepted;
    logic              dead;
  } nfa_report_t;

  // Clock, reset and every block input start at a known value.
  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = CFG_ACCEPT_MASK;
  logic [MASK_W-1:0]   cfg_wdata      = '0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] in_action      = ACT_LOAD;
  logic [SIDX_W-1:0]   in_state_index = '0;
  logic [SYM_W8-1:0]   in_symbol      = '0;
  logic [MASK_W-1:0]   in_target_mask = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [MASK_W-1:0]   out_active_set;
  logic                out_accepted;
  logic                out_dead;

  always #(CLK_PERIOD / 2) clk = ~clk;

  nfa_subset_simulator i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_state_index(in_state_index),
    .in_symbol     (in_symbol),
    .in_target_mask(in_target_mask),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_active_set(out_active_set),
    .out_accepted  (out_accepted),
    .out_dead      (out_dead)
  );

  // Behavioral copy of the automaton: transition rows, the active set and
  // the two configuration registers.
  logic [MASK_W-1:0] nfa_rows [NUM_STATES][SYM_COUNT];
  logic [MASK_W-1:0] live_set;
  logic [MASK_W-1:0] accept_reg;
  logic              digit_fold;

  nfa_report_t       pending_reports[$];
  nfa_report_t       oldest_report;
  int unsigned       mismatches  = 0;
  int unsigned       words_sent  = 0;
  int unsigned       cycle_count = 0;

  // Sender bookkeeping: whether in_valid is currently held high, and how
  // many more words go out back to back before the next gap.
  logic              offering   = 1'b0;
  int unsigned       burst_left = 0;

  // Receiver pattern state. The test flips hold_req to ask for a long
  // stall; the receiver notices the change and counts the stretch itself.
  logic              hold_req   = 1'b0;
  logic              hold_ack   = 1'b0;
  int unsigned       hold_left  = 0;
  int unsigned       stall_mode = 0;
  int unsigned       mode_left  = 0;
  logic [7:0]        stall_phase = '0;

  logic [SYM_W8-1:0] round_alphabet [5];

  // Union of the rows of every active state for one symbol.
  function automatic logic [MASK_W-1:0] step_targets(logic [MASK_W-1:0] from_set,
                                                     logic [SYM_W8-1:0] sym);
    logic [MASK_W-1:0] reach;
    reach = '0;
    for (int s = 0; s < NUM_STATES; s++)
      if (from_set[s]) reach |= nfa_rows[s][sym];
    return reach;
  endfunction

  // Epsilon closure as a fixed point over the epsilon rows. A cycle of
  // epsilon moves simply stops adding states, so the loop always ends.
  function automatic logic [MASK_W-1:0] eps_closure(logic [MASK_W-1:0] seed);
    logic [MASK_W-1:0] grown;
    logic [MASK_W-1:0] wider;
    grown = seed;
    for (int k = 0; k <= NUM_STATES; k++) begin
      wider = grown | step_targets(grown, SYM_EPSILON);
      if (wider == grown) break;
      grown = wider;
    end
    return grown;
  endfunction

  // Applies one accepted word to the copy and returns the result it owes.
  function automatic nfa_report_t predict_word(logic [ACTION_W-1:0] act,
                                               logic [SIDX_W-1:0]   sidx,
                                               logic [SYM_W8-1:0]   sym,
                                               logic [MASK_W-1:0]   tmask);
    logic [SYM_W8-1:0] lookup;
    case (act)
      ACT_LOAD:  nfa_rows[sidx][sym] = tmask;
      ACT_START: live_set = eps_closure(16'h0001);
      ACT_FEED: begin
        // A space leaves the set alone; digits may fold onto '~'.
        if (sym != SYM_SPACE) begin
          lookup = sym;
          if (digit_fold && sym >= DIGIT_LOW && sym <= DIGIT_HIGH)
            lookup = SYM_DIGIT_CLASS;
          live_set = eps_closure(step_targets(live_set, lookup));
        end
      end
      default: ;
    endcase
    return '{live_set, |(live_set & accept_reg), live_set == '0};
  endfunction

  // Mostly sparse target masks inside the states in use, so that runs do
  // not saturate, with an occasional full random mask to reach every bit.
  function automatic logic [MASK_W-1:0] sparse_mask(int unsigned n_live,
                                                    int unsigned zero_pct);
    int unsigned       pick;
    logic [MASK_W-1:0] bits;
    pick = $urandom_range(0, 99);
    bits = '0;
    if (pick >= zero_pct) begin
      bits = 16'h0001 << $urandom_range(0, n_live - 1);
      if (pick >= 80) bits |= 16'h0001 << $urandom_range(0, n_live - 1);
      if (pick >= 95) bits = 16'($urandom);
    end
    return bits;
  endfunction

  // Writes both registers, the accept mask first and then the digit-class
  // flag; only called while the block has nothing in flight.
  task automatic set_config(input logic [MASK_W-1:0] mask, input logic fold);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ACCEPT_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    accept_reg = mask;
    cfg_index <= CFG_DIGIT_CLASS;
    cfg_wdata <= {{(MASK_W - 1){1'b0}}, fold};
    @(posedge clk);
    digit_fold = fold;
    cfg_we <= 1'b0;
  endtask

  // Offers one word and waits for the block to take it. The word is
  // predicted at the accepting edge. Between bursts in_valid drops for a
  // random gap; within a burst it stays high into the next word.
  task automatic send_word(input logic [ACTION_W-1:0] act,
                           input logic [SIDX_W-1:0]   sidx,
                           input logic [SYM_W8-1:0]   sym,
                           input logic [MASK_W-1:0]   tmask);
    int unsigned gap;
    in_valid       <= 1'b1;
    in_action      <= act;
    in_state_index <= sidx;
    in_symbol      <= sym;
    in_target_mask <= tmask;
    offering = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_reports.push_back(predict_word(act, sidx, sym, tmask));
    words_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
  endtask

  // Stops offering and waits for every owed result word. Since each word
  // yields exactly one result, an empty queue means the block is idle.
  task automatic wait_all_reports();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Corner words with accept_mask at zero and digit folding on: a feed
  // before any start, the unused action, loads at the field extremes, an
  // epsilon cycle between states 1 and 2, character zero, a space, a
  // folded digit, symbol 255 and a feed on an empty set.
  task automatic test_corner_words();
    set_config(16'h0000, 1'b1);
    send_word(ACT_FEED,   4'd0,  CH_Z,            16'h0000);
    send_word(ACT_UNUSED, 4'd0,  8'h00,           16'h0000);
    send_word(ACT_START,  4'd0,  8'h00,           16'h0000);
    send_word(ACT_LOAD,   4'd15, CH_TOP,          16'hffff);
    send_word(ACT_LOAD,   4'd0,  CH_NUL,          16'h0002);
    send_word(ACT_LOAD,   4'd1,  SYM_EPSILON,     16'h0004);
    send_word(ACT_LOAD,   4'd2,  SYM_EPSILON,     16'h0002);
    send_word(ACT_LOAD,   4'd0,  SYM_DIGIT_CLASS, 16'h8000);
    send_word(ACT_LOAD,   4'd15, SYM_EPSILON,     16'h0001);
    send_word(ACT_START,  4'd0,  8'h00,           16'h0000);
    send_word(ACT_FEED,   4'd0,  CH_NUL,          16'h0000);
    send_word(ACT_FEED,   4'd0,  SYM_SPACE,       16'h0000);
    send_word(ACT_START,  4'd0,  8'h00,           16'h0000);
    send_word(ACT_FEED,   4'd0,  DIGIT_LOW + 8'd5, 16'h0000);
    send_word(ACT_FEED,   4'd0,  CH_TOP,          16'h0000);
    send_word(ACT_FEED,   4'd0,  CH_Z,            16'h0000);
    send_word(ACT_FEED,   4'd0,  DIGIT_LOW + 8'd7, 16'h0000);
    wait_all_reports();
  endtask

  // With folding off a digit is an ordinary character that has no row here,
  // while '~' itself still follows its row. Every state accepts.
  task automatic test_digit_folding_off();
    set_config(16'hffff, 1'b0);
    send_word(ACT_START, 4'd0, 8'h00,            16'h0000);
    send_word(ACT_FEED,  4'd0, DIGIT_LOW + 8'd5, 16'h0000);
    send_word(ACT_START, 4'd0, 8'h00,            16'h0000);
    send_word(ACT_FEED,  4'd0, SYM_DIGIT_CLASS,  16'h0000);
    send_word(ACT_FEED,  4'd0, CH_TOP,           16'h0000);
    wait_all_reports();
  endtask

  // A two-state ring on 'a'. The receiver is told to hold off for a long
  // stretch while the sender keeps offering, so the result register fills
  // and the block must push back on its input.
  task automatic test_output_backpressure();
    set_config(16'h0002, 1'b0);
    send_word(ACT_LOAD, 4'd0, CH_A,        16'h0002);
    send_word(ACT_LOAD, 4'd1, CH_A,        16'h0001);
    send_word(ACT_LOAD, 4'd0, SYM_EPSILON, 16'h0000);
    send_word(ACT_LOAD, 4'd1, SYM_EPSILON, 16'h0000);
    hold_req <= ~hold_req;
    send_word(ACT_START, 4'd0, 8'h00, 16'h0000);
    repeat (40)
      send_word(ACT_FEED, 4'($urandom), ($urandom_range(0, 3) == 0) ? SYM_SPACE : CH_A,
                16'($urandom));
    wait_all_reports();
  endtask

  // Random automata. Each round writes fresh registers, loads every row of
  // the states in use for a small alphabet (epsilon and '~' among it), then
  // starts and feeds a random string. A share of the words is noise: the
  // unused action, loads in mid-run and restarts.
  task automatic test_random_automata();
    int unsigned       n_live;
    int unsigned       pick;
    logic [SYM_W8-1:0] ch;
    while (words_sent < TOTAL_WORDS) begin
      wait_all_reports();
      n_live = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 8);
      case ($urandom_range(0, 4))
        0:       set_config(16'h0000, 1'($urandom_range(0, 1)));
        1:       set_config(16'hffff, 1'($urandom_range(0, 1)));
        2:       set_config(16'h0001 << $urandom_range(0, n_live - 1),
                            1'($urandom_range(0, 1)));
        default: set_config(16'($urandom), 1'($urandom_range(0, 1)));
      endcase
      round_alphabet[0] = SYM_EPSILON;
      round_alphabet[1] = SYM_DIGIT_CLASS;
      for (int k = 2; k < 5; k++)
        round_alphabet[k] = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(CH_A, CH_Z));
      // Rewrite the row of every state in use for each symbol of the round's
      // alphabet. Epsilon rows are kept emptier so that closures stay interesting.
      for (int s = 0; s < n_live; s++)
        for (int k = 0; k < 5; k++)
          send_word(ACT_LOAD, 4'(s), round_alphabet[k], sparse_mask(n_live, (k == 0) ? 60 : 40));
      send_word(ACT_START, 4'($urandom), 8'($urandom), 16'($urandom));
      repeat ($urandom_range(20, 60)) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          send_word(ACT_UNUSED, 4'($urandom), 8'($urandom), 16'($urandom));
        end else if (pick < 9) begin
          send_word(ACT_LOAD, 4'($urandom_range(0, n_live - 1)),
                    round_alphabet[$urandom_range(0, 4)], sparse_mask(n_live, 40));
        end else if (pick < 17 || (live_set == '0 && pick < 50)) begin
          send_word(ACT_START, 4'($urandom), 8'($urandom), 16'($urandom));
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 55)      ch = round_alphabet[$urandom_range(1, 4)];
          else if (pick < 75) ch = DIGIT_LOW + 8'($urandom_range(0, 9));
          else if (pick < 83) ch = SYM_SPACE;
          else if (pick < 88) ch = SYM_EPSILON;
          else if (pick < 91) ch = CH_NUL;
          else if (pick < 94) ch = CH_TOP;
          else                ch = 8'($urandom);
          send_word(ACT_FEED, 4'($urandom), ch, 16'($urandom));
        end
      end
    end
    wait_all_reports();
  endtask

  // Result checker and receiver stall pattern. Outputs are sampled at the
  // edge before any of this edge's updates land, so the handshake seen here
  // is exactly the one the block sees.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("result word with nothing expected: active_set %h", out_active_set);
        mismatches++;
      end else begin
        oldest_report = pending_reports.pop_front();
        if (out_active_set !== oldest_report.active) begin
          $error("active_set: expected %h, got %h", oldest_report.active, out_active_set);
          mismatches++;
        end
        if (out_accepted !== oldest_report.accepted) begin
          $error("accepted: expected %b, got %b", oldest_report.accepted, out_accepted);
          mismatches++;
        end
        if (out_dead !== oldest_report.dead) begin
          $error("dead: expected %b, got %b", oldest_report.dead, out_dead);
          mismatches++;
        end
      end
    end

    stall_phase <= stall_phase + 8'd1;
    if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      // At the end of each random-length run the pattern picks anew between never
      // stalling, light and heavy random stalls, and a regular square wave.
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_phase[2];
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < NUM_STATES; s++)
      for (int c = 0; c < SYM_COUNT; c++)
        nfa_rows[s][c] = '0;
    live_set   = '0;
    accept_reg = '0;
    digit_fold = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // The block clears its transition memory after reset and holds
    // in_stall meanwhile; the sender simply waits that out.
    test_corner_words();
    test_digit_folding_off();
    test_output_backpressure();
    test_random_automata();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/nss_pkg.sv
hw/rtl/nss_ram.sv
hw/rtl/nfa_subset_simulator.sv
sim/testbench.sv
